### rtl/core/sexp_pkg.sv
package sexp_pkg;

   localparam int POSITION_WIDTH_DEF = 16;
   localparam int VALUE_WIDTH_DEF    = 32;

   // result queue depth, a power of two holding two full runs
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [3:0] {
      KIND_OPEN    = 4'd0,
      KIND_CLOSE   = 4'd1,
      KIND_QUOTE   = 4'd2,
      KIND_IDENT   = 4'd3,
      KIND_STRING  = 4'd4,
      KIND_NUMBER  = 4'd5,
      KIND_TRUE    = 4'd6,
      KIND_FALSE   = 4'd7,
      KIND_BADHASH = 4'd8,
      KIND_END     = 4'd9
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_COMMENT = 3'd1,
      ST_HASH    = 3'd2,
      ST_STRING  = 3'd3,
      ST_NUMBER  = 3'd4,
      ST_IDENT   = 3'd5
   } scan_state_type;

   localparam logic [7:0] CHR_NUL    = 8'h00;
   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_NL     = 8'h0A;
   localparam logic [7:0] CHR_CR     = 8'h0D;
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_DQUOTE = 8'h22;
   localparam logic [7:0] CHR_HASH   = 8'h23;
   localparam logic [7:0] CHR_QUOTE  = 8'h27;
   localparam logic [7:0] CHR_OPEN   = 8'h28;
   localparam logic [7:0] CHR_CLOSE  = 8'h29;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_NINE   = 8'h39;
   localparam logic [7:0] CHR_SEMI   = 8'h3B;
   localparam logic [7:0] CHR_F      = 8'h66;
   localparam logic [7:0] CHR_T      = 8'h74;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHR_SPACE) || ((c >= CHR_TAB) && (c <= CHR_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHR_ZERO) && (c <= CHR_NINE);
   endfunction

endpackage

### rtl/core/sexp_text_if.sv
interface sexp_text_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] text_byte;

   modport source (output valid, output mode, output text_byte, input ready);
   modport sink   (input valid, input mode, input text_byte, output ready);
endinterface

### rtl/core/sexp_token_if.sv
interface sexp_token_if import sexp_pkg::*; #(
   parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
   parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF
);
   logic                      valid;
   logic                      ready;
   logic [3:0]                token_kind;
   logic [POSITION_WIDTH-1:0] start_line;
   logic [POSITION_WIDTH-1:0] start_column;
   logic [POSITION_WIDTH-1:0] token_length;
   logic [VALUE_WIDTH-1:0]    number_value;
   logic                      last_of_run;

   modport source (output valid, output token_kind, output start_line, output start_column,
                   output token_length, output number_value, output last_of_run,
                   input ready);
   modport sink   (input valid, input token_kind, input start_line, input start_column,
                   input token_length, input number_value, input last_of_run,
                   output ready);
endinterface

### rtl/core/s_expression_tokenizer.sv
// channel  | dir | handshake           | payload
// ---------+-----+---------------------+-----------------------------------------------
// req      | in  | req.valid/req.ready | mode, text_byte
// rsp      | out | rsp.valid/rsp.ready | token_kind, start_line, start_column,
//          |     |                     | token_length, number_value, last_of_run
//
// one item a cycle while the queue has room for two tokens: the byte sits in the input
// register while the scanner updates its state and pushes zero, one or two tokens into
// a four entry result queue, from which the first token of the item shows on rsp
// an item that gives two tokens takes two rsp transfers, the queue absorbs the extra one
// reset (synchronous) puts positions at line 1 column 1 and empties the queue
// a stalled rsp backs up into the queue, then the input register, then req.ready
module s_expression_tokenizer import sexp_pkg::*; #(
   parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
   parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF
) (
   input logic          clock,
   input logic          reset,
   sexp_text_if.sink    req,
   sexp_token_if.source rsp
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      kind_type                  kind;
      logic [POSITION_WIDTH-1:0] line;
      logic [POSITION_WIDTH-1:0] col;
      logic [POSITION_WIDTH-1:0] len;
      logic [VALUE_WIDTH-1:0]    value;
      logic                      last;
   } entry_type;

   // input register
   logic       in_v_ff, in_v_in;
   logic       in_mode_ff;
   logic [7:0] in_byte_ff;
   logic       take, proc;

   // scanner outputs
   logic [1:0]                     tok_count;
   kind_type                       tok_kind [2];
   logic [1:0][POSITION_WIDTH-1:0] tok_line, tok_column, tok_length;
   logic [1:0][VALUE_WIDTH-1:0]    tok_value;

   // result queue
   entry_type        q_ff [QUEUE_DEPTH];
   entry_type        ent0, ent1;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_nx, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       push_cnt;
   logic             pop;

   // the scanner runs only when the queue has room for a full two token run
   assign proc      = in_v_ff && (cnt_ff <= CNT_W'(QUEUE_DEPTH - 2));
   assign req.ready = !in_v_ff || proc;
   assign take      = req.valid && req.ready;
   assign in_v_in   = take ? 1'b1 : (proc ? 1'b0 : in_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= in_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_mode_ff <= req.mode;
         in_byte_ff <= req.text_byte;
      end
   end

   sexp_scan #(
      .POSITION_WIDTH (POSITION_WIDTH),
      .VALUE_WIDTH    (VALUE_WIDTH)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .step       (proc),
      .mode       (in_mode_ff),
      .text_byte  (in_byte_ff),
      .tok_count  (tok_count),
      .tok_kind   (tok_kind),
      .tok_line   (tok_line),
      .tok_column (tok_column),
      .tok_length (tok_length),
      .tok_value  (tok_value)
   );

   // last_of_run marks the final token of the item
   always_comb begin
      ent0 = '{kind: tok_kind[0], line: tok_line[0], col: tok_column[0],
               len: tok_length[0], value: tok_value[0], last: (tok_count == 2'd1)};
      ent1 = '{kind: tok_kind[1], line: tok_line[1], col: tok_column[1],
               len: tok_length[1], value: tok_value[1], last: 1'b1};
   end

   assign push_cnt  = proc ? tok_count : 2'd0;
   assign pop       = rsp.valid && rsp.ready;
   assign wr_ptr_nx = wr_ptr_ff + PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign cnt_in    = cnt_ff + CNT_W'(push_cnt) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (push_cnt != 2'd0 && wr_ptr_ff == PTR_W'(i)) begin
            q_ff[i] <= ent0;
         end else if (push_cnt == 2'd2 && wr_ptr_nx == PTR_W'(i)) begin
            q_ff[i] <= ent1;
         end
      end
   end

   assign rsp.valid        = (cnt_ff != CNT_W'(0));
   assign rsp.token_kind   = q_ff[rd_ptr_ff].kind;
   assign rsp.start_line   = q_ff[rd_ptr_ff].line;
   assign rsp.start_column = q_ff[rd_ptr_ff].col;
   assign rsp.token_length = q_ff[rd_ptr_ff].len;
   assign rsp.number_value = q_ff[rd_ptr_ff].value;
   assign rsp.last_of_run  = q_ff[rd_ptr_ff].last;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("result queue overrun");

   a_run_complete: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.last_of_run |-> cnt_ff >= CNT_W'(2))
      else $error("run split across a gap in the queue");

   a_held_item: assert property (@(posedge clock) disable iff (reset)
      in_v_ff && !proc |=> in_v_ff && $stable(in_byte_ff) && $stable(in_mode_ff))
      else $error("waiting item lost or changed");

endmodule

### rtl/core/sexp_scan.sv
module sexp_scan import sexp_pkg::*; #(
   parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
   parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic                           mode,
   input  logic [7:0]                     text_byte,
   output logic [1:0]                     tok_count,
   output kind_type                       tok_kind   [2],
   output logic [1:0][POSITION_WIDTH-1:0] tok_line,
   output logic [1:0][POSITION_WIDTH-1:0] tok_column,
   output logic [1:0][POSITION_WIDTH-1:0] tok_length,
   output logic [1:0][VALUE_WIDTH-1:0]    tok_value
);

   localparam logic [POSITION_WIDTH-1:0] POS_MAX  = '1;
   localparam logic [POSITION_WIDTH-1:0] POS_ZERO = POSITION_WIDTH'(0);
   localparam logic [POSITION_WIDTH-1:0] POS_ONE  = POSITION_WIDTH'(1);
   localparam logic [POSITION_WIDTH-1:0] POS_TWO  = POSITION_WIDTH'(2);
   localparam logic [VALUE_WIDTH-1:0]    VAL_ZERO = VALUE_WIDTH'(0);

   function automatic logic [POSITION_WIDTH-1:0] sat_inc(input logic [POSITION_WIDTH-1:0] v);
      return (v == POS_MAX) ? v : v + POS_ONE;
   endfunction

   scan_state_type            state_ff, state_in;
   logic [POSITION_WIDTH-1:0] line_ff, line_in;
   logic [POSITION_WIDTH-1:0] col_ff, col_in;
   logic [POSITION_WIDTH-1:0] tline_ff, tline_in;
   logic [POSITION_WIDTH-1:0] tcol_ff, tcol_in;
   logic [POSITION_WIDTH-1:0] len_ff, len_in;
   logic [VALUE_WIDTH-1:0]    acc_ff, acc_in;
   logic                      done_ff, done_in;

   // first slot: pending token flushed or #t/#f; second slot: fresh token or end
   logic                      a_v, b_v, fresh;
   kind_type                  a_kind, b_kind;
   logic [POSITION_WIDTH-1:0] a_line, a_col, a_len, b_line, b_col, b_len;
   logic [VALUE_WIDTH-1:0]    a_val, digit_val, acc_x10;
   logic                      eot;

   assign eot       = mode || (text_byte == CHR_NUL);
   assign digit_val = {{(VALUE_WIDTH-4){1'b0}}, text_byte[3:0]};
   assign acc_x10   = (acc_ff << 3) + (acc_ff << 1) + digit_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         line_ff  <= POS_ONE;
         col_ff   <= POS_ONE;
         tline_ff <= POS_ONE;
         tcol_ff  <= POS_ONE;
         len_ff   <= POS_ZERO;
         acc_ff   <= VAL_ZERO;
         done_ff  <= 1'b0;
      end else if (step) begin
         state_ff <= state_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         tline_ff <= tline_in;
         tcol_ff  <= tcol_in;
         len_ff   <= len_in;
         acc_ff   <= acc_in;
         done_ff  <= done_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      tline_in = tline_ff;
      tcol_in  = tcol_ff;
      len_in   = len_ff;
      acc_in   = acc_ff;
      done_in  = done_ff;
      fresh    = 1'b0;

      a_v    = 1'b0;
      a_kind = KIND_BADHASH;
      a_line = tline_ff;
      a_col  = tcol_ff;
      a_len  = len_ff;
      a_val  = VAL_ZERO;

      b_v    = 1'b0;
      b_kind = KIND_END;
      b_line = line_ff;
      b_col  = col_ff;
      b_len  = POS_ZERO;

      // pending token, used on end of text and when a byte closes it
      case (state_ff)
         ST_HASH:   begin a_kind = KIND_BADHASH; a_len = POS_ONE; end
         ST_STRING: a_kind = KIND_STRING;
         ST_NUMBER: begin a_kind = KIND_NUMBER; a_val = acc_ff; end
         ST_IDENT:  a_kind = KIND_IDENT;
         default:   a_kind = KIND_BADHASH;
      endcase

      if (done_ff) begin
         b_v = 1'b1;
      end else if (eot) begin
         a_v      = (state_ff != ST_IDLE) && (state_ff != ST_COMMENT);
         b_v      = 1'b1;
         state_in = ST_IDLE;
         done_in  = 1'b1;
      end else begin
         case (state_ff)
            ST_COMMENT: begin
               if (text_byte == CHR_NL) state_in = ST_IDLE;
            end
            ST_HASH: begin
               if (text_byte == CHR_T || text_byte == CHR_F) begin
                  a_v      = 1'b1;
                  a_kind   = (text_byte == CHR_T) ? KIND_TRUE : KIND_FALSE;
                  a_len    = POS_TWO;
                  state_in = ST_IDLE;
               end else begin
                  a_v   = 1'b1;
                  fresh = 1'b1;
               end
            end
            ST_STRING: begin
               if (text_byte == CHR_DQUOTE) begin
                  a_v      = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  len_in = sat_inc(len_ff);
               end
            end
            ST_NUMBER: begin
               if (is_digit(text_byte)) begin
                  acc_in = acc_x10;
                  len_in = sat_inc(len_ff);
               end else begin
                  a_v   = 1'b1;
                  fresh = 1'b1;
               end
            end
            ST_IDENT: begin
               if (is_space(text_byte) || text_byte == CHR_CLOSE) begin
                  a_v   = 1'b1;
                  fresh = 1'b1;
               end else begin
                  len_in = sat_inc(len_ff);
               end
            end
            default: fresh = 1'b1;
         endcase

         // byte opens whatever follows
         if (fresh) begin
            state_in = ST_IDLE;
            b_len    = POS_ONE;
            if (is_space(text_byte)) begin
               state_in = ST_IDLE;
            end else if (text_byte == CHR_SEMI) begin
               state_in = ST_COMMENT;
            end else if (text_byte == CHR_QUOTE) begin
               b_v    = 1'b1;
               b_kind = KIND_QUOTE;
            end else if (text_byte == CHR_OPEN) begin
               b_v    = 1'b1;
               b_kind = KIND_OPEN;
            end else if (text_byte == CHR_CLOSE) begin
               b_v    = 1'b1;
               b_kind = KIND_CLOSE;
            end else if (text_byte == CHR_HASH) begin
               tline_in = line_ff;
               tcol_in  = col_ff;
               state_in = ST_HASH;
            end else if (text_byte == CHR_DQUOTE) begin
               // string starts at the byte after the quote
               tline_in = line_ff;
               tcol_in  = sat_inc(col_ff);
               len_in   = POS_ZERO;
               state_in = ST_STRING;
            end else begin
               tline_in = line_ff;
               tcol_in  = col_ff;
               len_in   = POS_ONE;
               if (is_digit(text_byte)) begin
                  acc_in   = digit_val;
                  state_in = ST_NUMBER;
               end else begin
                  acc_in   = VAL_ZERO;
                  state_in = ST_IDENT;
               end
            end
         end

         if (text_byte == CHR_NL) begin
            line_in = sat_inc(line_ff);
            col_in  = POS_ONE;
         end else begin
            col_in = sat_inc(col_ff);
         end
      end

      // pack the two candidate tokens into the lowest slots
      if (a_v) begin
         tok_count     = b_v ? 2'd2 : 2'd1;
         tok_kind[0]   = a_kind;
         tok_line[0]   = a_line;
         tok_column[0] = a_col;
         tok_length[0] = a_len;
         tok_value[0]  = a_val;
      end else begin
         tok_count     = b_v ? 2'd1 : 2'd0;
         tok_kind[0]   = b_kind;
         tok_line[0]   = b_line;
         tok_column[0] = b_col;
         tok_length[0] = b_len;
         tok_value[0]  = VAL_ZERO;
      end
      tok_kind[1]   = b_kind;
      tok_line[1]   = b_line;
      tok_column[1] = b_col;
      tok_length[1] = b_len;
      tok_value[1]  = VAL_ZERO;
   end

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff)
      else $error("end of text flag dropped");

   a_done_frozen: assert property (@(posedge clock) disable iff (reset)
      step && done_ff |=> $stable(line_ff) && $stable(col_ff) && $stable(state_ff))
      else $error("state moved after end of text");

   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      step && (eot || done_ff) |-> tok_count != 2'd0)
      else $error("end of text gave no token");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      tok_count != 2'd3)
      else $error("more than two tokens from one item");

endmodule

### tb/sv/s_expression_tokenizer_test.sv
module s_expression_tokenizer_test;
   import sexp_pkg::*;

   localparam int PW = POSITION_WIDTH_DEF;
   localparam int VW = VALUE_WIDTH_DEF;

   // quiet cycles tolerated before the run is called hung
   localparam int WATCHDOG_LIMIT = 1000;
   // long receiver hold-off, well under the watchdog limit
   localparam int HOLD_CYCLES    = 150;
   // cycles allowed after the last token for stray output to show
   localparam int SETTLE_CYCLES  = 8;

   // one token as seen on the result channel
   typedef struct {
      logic [3:0]    kind;
      logic [PW-1:0] start_line;
      logic [PW-1:0] start_column;
      logic [PW-1:0] token_length;
      logic [VW-1:0] number_value;
      logic          last_of_run;
   } token_type;

   // tokenizer predictor plus the list of tokens still owed by the block
   class token_scoreboard_type;
      token_type      expected_tokens[$];
      token_type      run_tokens[$];
      int             errors;
      scan_state_type state;
      logic [PW-1:0]  line_no;
      logic [PW-1:0]  column_no;
      logic [PW-1:0]  tok_line;
      logic [PW-1:0]  tok_column;
      logic [PW-1:0]  length_no;
      logic [VW-1:0]  value_acc;
      bit             finished;

      function new();
         errors     = 0;
         state      = ST_IDLE;
         line_no    = 1;
         column_no  = 1;
         tok_line   = 1;
         tok_column = 1;
         length_no  = 0;
         value_acc  = 0;
         finished   = 0;
      endfunction

      function bit is_white(logic [7:0] c);
         return (c == CHR_SPACE) || ((c >= CHR_TAB) && (c <= CHR_CR));
      endfunction

      function bit is_numeral(logic [7:0] c);
         return (c >= CHR_ZERO) && (c <= CHR_NINE);
      endfunction

      // saturating position and length counter
      function logic [PW-1:0] bump(logic [PW-1:0] v);
         return (v == {PW{1'b1}}) ? v : v + 1'b1;
      endfunction

      function void push_token(kind_type k, logic [PW-1:0] ln, logic [PW-1:0] col,
                               logic [PW-1:0] len, logic [VW-1:0] val);
         token_type t;
         t.kind         = k;
         t.start_line   = ln;
         t.start_column = col;
         t.token_length = len;
         t.number_value = val;
         t.last_of_run  = 1'b0;
         if (run_tokens.size() < 2) run_tokens.push_back(t);
      endfunction

      // a byte seen between tokens
      function void open_token(logic [7:0] c);
         state = ST_IDLE;
         if (!is_white(c)) begin
            case (c)
               CHR_SEMI:  state = ST_COMMENT;
               CHR_QUOTE: push_token(KIND_QUOTE, line_no, column_no, 1, 0);
               CHR_OPEN:  push_token(KIND_OPEN, line_no, column_no, 1, 0);
               CHR_CLOSE: push_token(KIND_CLOSE, line_no, column_no, 1, 0);
               CHR_HASH: begin
                  tok_line   = line_no;
                  tok_column = column_no;
                  state      = ST_HASH;
               end
               CHR_DQUOTE: begin
                  // string starts at the byte after the quote
                  tok_line   = line_no;
                  tok_column = bump(column_no);
                  length_no  = 0;
                  state      = ST_STRING;
               end
               default: begin
                  tok_line   = line_no;
                  tok_column = column_no;
                  length_no  = 1;
                  if (is_numeral(c)) begin
                     value_acc = VW'(c - CHR_ZERO);
                     state     = ST_NUMBER;
                  end else begin
                     value_acc = 0;
                     state     = ST_IDENT;
                  end
               end
            endcase
         end
      endfunction

      // emit whatever token is half built
      function void close_token();
         case (state)
            ST_HASH:   push_token(KIND_BADHASH, tok_line, tok_column, 1, 0);
            ST_STRING: push_token(KIND_STRING, tok_line, tok_column, length_no, 0);
            ST_NUMBER: push_token(KIND_NUMBER, tok_line, tok_column, length_no, value_acc);
            ST_IDENT:  push_token(KIND_IDENT, tok_line, tok_column, length_no, 0);
            default: ;
         endcase
         state = ST_IDLE;
      endfunction

      function void note_item(logic mode, logic [7:0] c);
         token_type t;
         run_tokens.delete();
         if (finished) begin
            push_token(KIND_END, line_no, column_no, 0, 0);
         end else if (mode || (c == CHR_NUL)) begin
            close_token();
            push_token(KIND_END, line_no, column_no, 0, 0);
            finished = 1;
         end else begin
            case (state)
               ST_COMMENT: begin
                  if (c == CHR_NL) state = ST_IDLE;
               end
               ST_HASH: begin
                  if (c == CHR_T) begin
                     push_token(KIND_TRUE, tok_line, tok_column, 2, 0);
                     state = ST_IDLE;
                  end else if (c == CHR_F) begin
                     push_token(KIND_FALSE, tok_line, tok_column, 2, 0);
                     state = ST_IDLE;
                  end else begin
                     close_token();
                     open_token(c);
                  end
               end
               ST_STRING: begin
                  if (c == CHR_DQUOTE) close_token();
                  else length_no = bump(length_no);
               end
               ST_NUMBER: begin
                  if (is_numeral(c)) begin
                     value_acc = value_acc * VW'(10) + VW'(c - CHR_ZERO);
                     length_no = bump(length_no);
                  end else begin
                     close_token();
                     open_token(c);
                  end
               end
               ST_IDENT: begin
                  if (is_white(c) || (c == CHR_CLOSE)) begin
                     close_token();
                     open_token(c);
                  end else begin
                     length_no = bump(length_no);
                  end
               end
               default: open_token(c);
            endcase
            if (c == CHR_NL) begin
               line_no   = bump(line_no);
               column_no = 1;
            end else begin
               column_no = bump(column_no);
            end
         end
         foreach (run_tokens[i]) begin
            t = run_tokens[i];
            t.last_of_run = (i == run_tokens.size() - 1);
            expected_tokens.push_back(t);
         end
      endfunction

      function void compare_field(string name, logic [VW-1:0] want, logic [VW-1:0] got);
         if (want !== got) begin
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_token(token_type got);
         token_type want;
         if (expected_tokens.size() == 0) begin
            $display("%0t unexpected token: expected none, actual kind %0d", $time, got.kind);
            errors++;
         end else begin
            want = expected_tokens.pop_front();
            compare_field("token_kind", want.kind, got.kind);
            compare_field("start_line", want.start_line, got.start_line);
            compare_field("start_column", want.start_column, got.start_column);
            compare_field("token_length", want.token_length, got.token_length);
            compare_field("number_value", want.number_value, got.number_value);
            compare_field("last_of_run", want.last_of_run, got.last_of_run);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   sexp_text_if  text_ch ();
   sexp_token_if tok_ch ();

   s_expression_tokenizer dut (
      .clock (clock),
      .reset (reset),
      .req   (text_ch),
      .rsp   (tok_ch)
   );

   token_scoreboard_type tokens = new();

   // source text waiting to be offered, one entry per item
   logic [7:0] text_q[$];
   token_type  seen_token;

   // idling controls, in percent of cycles
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   // hold-offs asked for by the stimulus and those already begun by the receiver
   int hold_requests  = 0;
   int holds_started  = 0;
   int hold_left      = 0;
   int idle_cycles;

   string ident_chars = "abcdefghijklmnopqrstuvwxyzQZ+-*/<>=!?_.";

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // both channels are sampled here with pre-edge values, so the order
   // against the driving processes in the same step does not matter
   always @(posedge clock) begin
      if (!reset) begin
         if (text_ch.valid && text_ch.ready)
            tokens.note_item(text_ch.mode, text_ch.text_byte);
         if (tok_ch.valid && tok_ch.ready) begin
            seen_token.kind         = tok_ch.token_kind;
            seen_token.start_line   = tok_ch.start_line;
            seen_token.start_column = tok_ch.start_column;
            seen_token.token_length = tok_ch.token_length;
            seen_token.number_value = tok_ch.number_value;
            seen_token.last_of_run  = tok_ch.last_of_run;
            tokens.check_token(seen_token);
         end
      end
   end

   // receiver: random stalls, or a long hold-off counted out here
   always @(posedge clock) begin
      if (hold_requests != holds_started) begin
         hold_left     = HOLD_CYCLES;
         holds_started = hold_requests;
      end
      if (reset) begin
         tok_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         tok_ch.ready <= 1'b0;
         hold_left--;
      end else begin
         tok_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog: too long with nothing moving on either channel
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((text_ch.valid && text_ch.ready) || (tok_ch.valid && tok_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // offer one item and wait for the edge that takes it; valid stays high
   // afterwards so back-to-back items need no second assignment per step
   task automatic send_item(logic mode, logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         text_ch.valid <= 1'b0;
         @(posedge clock);
      end
      text_ch.valid     <= 1'b1;
      text_ch.mode      <= mode;
      text_ch.text_byte <= value;
      @(posedge clock);
      while (!text_ch.ready) @(posedge clock);
   endtask

   task automatic send_text();
      while (text_q.size() != 0) send_item(1'b0, text_q.pop_front());
   endtask

   // sender stands back until every owed token has come out
   task automatic wait_for_tokens();
      text_ch.valid <= 1'b0;
      do @(posedge clock); while (tokens.expected_tokens.size() != 0);
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   // mostly short numbers, some long enough to wrap the value
   task automatic add_number();
      int n;
      n = ($urandom_range(9) < 7) ? $urandom_range(1, 4) : $urandom_range(9, 14);
      repeat (n) text_q.push_back(CHR_ZERO + 8'($urandom_range(9)));
   endtask

   task automatic add_ident();
      logic [7:0] c;
      int n;
      // first byte must not open any other kind of token
      if ($urandom_range(1)) begin
         c = ident_chars[$urandom_range(ident_chars.len() - 1)];
      end else begin
         do c = 8'($urandom_range(1, 255));
         while (tokens.is_white(c) || tokens.is_numeral(c) || c == CHR_SEMI ||
                c == CHR_QUOTE || c == CHR_OPEN || c == CHR_CLOSE || c == CHR_HASH ||
                c == CHR_DQUOTE);
      end
      text_q.push_back(c);
      n = $urandom_range(0, 7);
      repeat (n) begin
         if ($urandom_range(2) != 0) begin
            c = ident_chars[$urandom_range(ident_chars.len() - 1)];
         end else begin
            do c = 8'($urandom_range(1, 255));
            while (tokens.is_white(c) || c == CHR_CLOSE);
         end
         text_q.push_back(c);
      end
   endtask

   task automatic add_string(bit closed);
      logic [7:0] c;
      int n;
      text_q.push_back(CHR_DQUOTE);
      n = $urandom_range(0, 6);
      repeat (n) begin
         do c = 8'($urandom_range(1, 255)); while (c == CHR_DQUOTE);
         if ($urandom_range(9) == 0) c = CHR_NL;
         text_q.push_back(c);
      end
      if (closed) text_q.push_back(CHR_DQUOTE);
   endtask

   task automatic add_comment(bit closed);
      logic [7:0] c;
      int n;
      text_q.push_back(CHR_SEMI);
      n = $urandom_range(0, 8);
      repeat (n) begin
         do c = 8'($urandom_range(1, 255)); while (c == CHR_NL);
         text_q.push_back(c);
      end
      if (closed) text_q.push_back(CHR_NL);
   endtask

   // whitespace of every kind, a close, an open, or nothing at all
   task automatic add_separator();
      case ($urandom_range(9))
         0, 1, 2: text_q.push_back(CHR_SPACE);
         3:       text_q.push_back(CHR_NL);
         4:       text_q.push_back(8'($urandom_range(CHR_TAB, CHR_CR)));
         5, 6:    text_q.push_back(CHR_CLOSE);
         7:       text_q.push_back(CHR_OPEN);
         default: ;
      endcase
   endtask

   // one well-formed piece of source text, now and then plain noise
   task automatic add_fragment();
      logic [7:0] c;
      case ($urandom_range(19))
         0, 1:    text_q.push_back(CHR_OPEN);
         2, 3:    text_q.push_back(CHR_CLOSE);
         4:       text_q.push_back(CHR_QUOTE);
         5, 6, 7: begin
            add_number();
            add_separator();
         end
         8, 9, 10: begin
            add_ident();
            add_separator();
         end
         11, 12:  add_string(1'b1);
         13: begin
            text_q.push_back(CHR_HASH);
            text_q.push_back(CHR_T);
         end
         14: begin
            text_q.push_back(CHR_HASH);
            text_q.push_back(CHR_F);
         end
         15: begin
            // bad hash, the next byte then starts afresh
            text_q.push_back(CHR_HASH);
            do c = 8'($urandom_range(1, 255)); while (c == CHR_T || c == CHR_F);
            text_q.push_back(c);
         end
         16:      add_comment(1'b1);
         17:      add_separator();
         default: text_q.push_back(8'($urandom_range(1, 255)));
      endcase
   endtask

   task automatic run_phase(int send_pct, int recv_pct, int count);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      while (text_q.size() < count) add_fragment();
      send_text();
   endtask

   initial begin
      reset             <= 1'b1;
      text_ch.valid     <= 1'b0;
      text_ch.mode      <= 1'b0;
      text_ch.text_byte <= CHR_NUL;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: every token kind but end, a bad hash that splits into two tokens,
      // an empty string, a number that wraps to zero and ends on a close,
      // a top-bit byte as identifier, and a comment to end of line
      push_text("(#t#f#('\"\"4294967296)");
      text_q.push_back(8'hFF);
      push_text(" ;c\n");
      send_text();

      // no idling at all
      run_phase(0, 0, 250);

      // receiver holds off for a long stretch while the sender keeps offering,
      // so the result queue and then the input stall
      hold_requests++;
      run_phase(0, 0, 40);
      wait_for_tokens();

      run_phase(85, 0, 230);
      run_phase(0, 85, 230);
      run_phase(29, 29, 230);
      wait_for_tokens();

      // text ends inside a token, a comment, or between tokens
      send_idle_pct  = 29;
      recv_stall_pct = 29;
      case ($urandom_range(5))
         0: add_number();
         1: add_ident();
         2: add_string(1'b0);
         3: text_q.push_back(CHR_HASH);
         4: add_comment(1'b0);
         default: add_separator();
      endcase
      send_text();

      // end of text by mode or by a zero byte, then input after the end
      if ($urandom_range(1)) send_item(1'b1, 8'($urandom_range(255)));
      else send_item(1'b0, CHR_NUL);
      repeat (24) send_item(1'($urandom_range(1)), 8'($urandom_range(255)));

      wait_for_tokens();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if ((tokens.errors == 0) && (tokens.expected_tokens.size() == 0))
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### files.f
rtl/core/sexp_pkg.sv
rtl/core/sexp_text_if.sv
rtl/core/sexp_token_if.sv
rtl/core/sexp_scan.sv
rtl/core/s_expression_tokenizer.sv
tb/sv/s_expression_tokenizer_test.sv
